[rtl/cmre_pkg.sv]
// Shared types and constants for the CIGAR match-run expander.
// Used by cmre_front, cmre_queue, cmre_back and cigar_match_run_expander.
`default_nettype none

package cmre_pkg;

    // Field widths fixed by the stream format.
    localparam int CODE_W = 4;
    localparam int LEN_W  = 28;
    localparam int BASE_W = 8;

    // Extended CIGAR op codes produced for runs.
    localparam logic [CODE_W-1:0] OP_SEQ_MATCH    = 4'd7;
    localparam logic [CODE_W-1:0] OP_SEQ_MISMATCH = 4'd8;

    // Depth of the queue between the classifier and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One emitted operation.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_result;

    // All results caused by one input item: one or two operations.
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

endpackage

`default_nettype wire

[rtl/cmre_front.sv]
// Front end: accepts items, keeps the open run and classifies each item
// into the operations it emits. Depends on cmre_pkg.
`default_nettype none

module cmre_front #(
    parameter int LENGTH_BITS = 28
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_item_valid,
    output logic                            o_item_ready,
    input  wire logic                       i_kind,
    input  wire logic [cmre_pkg::CODE_W-1:0] i_op_code,
    input  wire logic [cmre_pkg::LEN_W-1:0]  i_op_length,
    input  wire logic [cmre_pkg::BASE_W-1:0] i_query_base,
    input  wire logic [cmre_pkg::BASE_W-1:0] i_ref_base,
    input  wire logic                       i_last_column,
    input  wire logic                       i_queue_ready,
    output logic                            o_push,
    output cmre_pkg::t_entry                o_entry
);

    logic                   r_run_is_mismatch;
    logic [LENGTH_BITS-1:0] r_run_count;
    logic                   r_run_open;
    logic                   n_run_is_mismatch;
    logic [LENGTH_BITS-1:0] n_run_count;
    logic                   n_run_open;

    logic                   w_accept;
    logic                   w_mis;
    logic                   w_emit_old;
    logic                   w_emit_new;
    logic [LENGTH_BITS-1:0] w_col_count;
    logic [cmre_pkg::LEN_W-1:0] w_old_len;
    logic [cmre_pkg::LEN_W-1:0] w_col_len;
    cmre_pkg::t_result      w_old_res;
    cmre_pkg::t_result      w_new_res;

    assign w_accept     = i_item_valid && i_queue_ready;
    assign o_item_ready = i_queue_ready;
    assign w_mis        = (i_query_base != i_ref_base);

    // Run counts are shown on the fixed-width length field.
    if (LENGTH_BITS >= cmre_pkg::LEN_W) begin : g_len_trunc
        assign w_old_len = r_run_count[cmre_pkg::LEN_W-1:0];
        assign w_col_len = w_col_count[cmre_pkg::LEN_W-1:0];
    end else begin : g_len_ext
        assign w_old_len = {{(cmre_pkg::LEN_W-LENGTH_BITS){1'b0}}, r_run_count};
        assign w_col_len = {{(cmre_pkg::LEN_W-LENGTH_BITS){1'b0}}, w_col_count};
    end

    // The open run as it stands before this item.
    always_comb begin
        w_old_res.code = r_run_is_mismatch ? cmre_pkg::OP_SEQ_MISMATCH
                                           : cmre_pkg::OP_SEQ_MATCH;
        w_old_res.len  = w_old_len;
    end

    // Column count after this column: a new run starts at one, an extended
    // run saturates at its all-ones value.
    always_comb begin
        if (!r_run_open || (w_mis != r_run_is_mismatch)) begin
            w_col_count = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end else if (r_run_count != {LENGTH_BITS{1'b1}}) begin
            w_col_count = r_run_count + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end else begin
            w_col_count = r_run_count;
        end
    end

    // Classify the item: which earlier run closes, what else is emitted,
    // and how the run state moves on.
    always_comb begin
        n_run_is_mismatch = r_run_is_mismatch;
        n_run_count       = r_run_count;
        n_run_open        = r_run_open;
        w_new_res         = '0;
        if (!i_kind) begin
            w_emit_old     = r_run_open;
            w_emit_new     = (i_op_length != '0);
            w_new_res.code = i_op_code;
            w_new_res.len  = i_op_length;
            n_run_open     = 1'b0;
            n_run_count    = '0;
        end else begin
            w_emit_old        = r_run_open && (w_mis != r_run_is_mismatch);
            w_emit_new        = i_last_column;
            w_new_res.code    = w_mis ? cmre_pkg::OP_SEQ_MISMATCH
                                      : cmre_pkg::OP_SEQ_MATCH;
            w_new_res.len     = w_col_len;
            n_run_is_mismatch = w_mis;
            n_run_open        = !i_last_column;
            n_run_count       = i_last_column ? '0 : w_col_count;
        end
    end

    // Pack the item's results, the earlier run always first.
    always_comb begin
        o_push         = w_accept && (w_emit_old || w_emit_new);
        o_entry.two    = w_emit_old && w_emit_new;
        o_entry.first  = w_emit_old ? w_old_res : w_new_res;
        o_entry.second = w_new_res;
    end

    // Run state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_is_mismatch <= 1'b0;
            r_run_count       <= '0;
            r_run_open        <= 1'b0;
        end else if (w_accept) begin
            r_run_is_mismatch <= n_run_is_mismatch;
            r_run_count       <= n_run_count;
            r_run_open        <= n_run_open;
        end
    end

endmodule

`default_nettype wire

[rtl/cmre_queue.sv]
// Short queue of result entries between the front end and the output stage.
// Depends on cmre_pkg.
`default_nettype none

module cmre_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cmre_pkg::t_entry i_entry,
    output logic                 o_ready,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output cmre_pkg::t_entry     o_entry
);

    cmre_pkg::t_entry                r_mem [cmre_pkg::QUEUE_DEPTH];
    logic [cmre_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [cmre_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [cmre_pkg::QCNT_W-1:0]     r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_ready = (r_count != cmre_pkg::QCNT_W'(cmre_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cmre_back.sv]
// Output stage: takes entries from the queue and sends their operations one
// per transaction through an output register. Depends on cmre_pkg.
`default_nettype none

module cmre_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire cmre_pkg::t_entry            i_entry,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [cmre_pkg::CODE_W-1:0]      o_op_code,
    output logic [cmre_pkg::LEN_W-1:0]       o_op_length,
    output logic                             o_tlast
);

    logic              r_out_valid;
    cmre_pkg::t_result r_out;
    logic              r_out_last;
    logic              r_sec_valid;
    cmre_pkg::t_result r_sec;
    logic              w_load;

    // The output register may be refilled when empty or being taken.
    assign w_load = !r_out_valid || i_tready;
    assign o_pop  = w_load && !r_sec_valid && i_valid;

    assign o_tvalid    = r_out_valid;
    assign o_op_code   = r_out.code;
    assign o_op_length = r_out.len;
    assign o_tlast     = r_out_last;

    // Valid flags: the held second operation goes out before the next entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else if (w_load) begin
            if (r_sec_valid) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_sec_valid <= i_valid && i_entry.two;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_sec_valid) begin
                r_out      <= r_sec;
                r_out_last <= 1'b1;
            end else if (i_valid) begin
                r_out      <= i_entry.first;
                r_out_last <= !i_entry.two;
                r_sec      <= i_entry.second;
            end
        end
    end

    // A held second operation always sits behind a shown first one.
    a_sec_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> r_out_valid)
        else $error("second operation held without a first one on the output");

    // A result that does not end its burst is always followed by a held one.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_sec_valid)
        else $error("burst left open with no second operation held");

    // No queue entry is taken while a second operation is still waiting.
    a_no_pop_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_valid |-> !o_pop)
        else $error("queue popped while a second operation was waiting");

endmodule

`default_nettype wire

[rtl/cigar_match_run_expander.sv]
// A result passes through the queue and then the output register after its item is
// accepted, and can be taken from there.
// Throughput: one item per cycle while the queue has room; an item that emits two operations
// holds the output register for both, and the four-entry queue absorbs such bursts.
// Reset (i_rst_n, synchronous, active low) closes any open run and empties the queue.
`default_nettype none

module cigar_match_run_expander #(
    parameter int LENGTH_BITS = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: op_code [3:0], op_length [31:4], query_base [39:32], ref_base [47:40]
    input  wire logic [47:0] s_axis_tdata,
    // tuser: kind [0]
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_op_code [3:0], out_op_length [31:4]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic                          w_push;
    logic                          w_queue_ready;
    cmre_pkg::t_entry              w_push_entry;
    logic                          w_queue_valid;
    cmre_pkg::t_entry              w_head_entry;
    logic                          w_pop;
    logic [cmre_pkg::CODE_W-1:0]   w_out_code;
    logic [cmre_pkg::LEN_W-1:0]    w_out_len;

    // Classifier and run tracker.
    cmre_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (s_axis_tvalid),
        .o_item_ready  (s_axis_tready),
        .i_kind        (s_axis_tuser[0]),
        .i_op_code     (s_axis_tdata[3:0]),
        .i_op_length   (s_axis_tdata[31:4]),
        .i_query_base  (s_axis_tdata[39:32]),
        .i_ref_base    (s_axis_tdata[47:40]),
        .i_last_column (s_axis_tlast),
        .i_queue_ready (w_queue_ready),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    // Decoupling queue.
    cmre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_entry (w_head_entry)
    );

    // Serialiser and output register.
    cmre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_queue_valid),
        .i_entry     (w_head_entry),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_op_code   (w_out_code),
        .o_op_length (w_out_len),
        .o_tlast     (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_len, w_out_code};

endmodule

`default_nettype wire

[test/cigar_match_run_expander_test.sv]
// Self-checking testbench for cigar_match_run_expander: drives CIGAR items on the slave stream
// and compares every master-stream transaction with an in-bench prediction of the = / X runs.
// Depends on cmre_pkg and the expander RTL only.
`default_nettype none

module cigar_match_run_expander_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LENGTH_BITS  = 28;
    localparam int ITEM_TARGET  = 1950;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 30;

    // Item kinds carried in tuser.
    localparam logic KIND_WHOLE_OP = 1'b0;
    localparam logic KIND_COLUMN   = 1'b1;

    // Basic CIGAR op codes; = and X come from the package.
    localparam logic [cmre_pkg::CODE_W-1:0] OP_ALN_MATCH  = 4'd0;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_INS        = 4'd1;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_DEL        = 4'd2;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_SKIP       = 4'd3;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_SOFT_CLIP  = 4'd4;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_HARD_CLIP  = 4'd5;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_PAD        = 4'd6;
    localparam logic [cmre_pkg::CODE_W-1:0] OP_CODE_TOP   = 4'd15;

    localparam logic [cmre_pkg::LEN_W-1:0] LEN_ALL_ONES = '1;
    localparam logic [LENGTH_BITS-1:0]     RUN_MAX      = '1;

    typedef struct packed {
        logic                        kind;
        logic [cmre_pkg::CODE_W-1:0] code;
        logic [cmre_pkg::LEN_W-1:0]  len;
        logic [cmre_pkg::BASE_W-1:0] qbase;
        logic [cmre_pkg::BASE_W-1:0] rbase;
        logic                        last;
    } t_cigar_item;

    typedef struct packed {
        logic [cmre_pkg::CODE_W-1:0] code;
        logic [cmre_pkg::LEN_W-1:0]  len;
        logic                        last;
    } t_cigar_op;

    localparam int ITEM_W = $bits(t_cigar_item);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: op_code [3:0], op_length [31:4], query_base [39:32], ref_base [47:40]
    logic [47:0] s_axis_tdata = '0;
    // tuser: kind [0]
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: out_op_code [3:0], out_op_length [31:4]
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_cigar_item pending_items[$];
    t_cigar_op   expected_ops[$];
    t_cigar_item cur_item;

    // Predicted state of the open = / X run.
    logic                   run_mis = 1'b0;
    logic [LENGTH_BITS-1:0] run_len = '0;
    logic                   run_on = 1'b0;

    int   errors = 0;
    int   total_items = 0;
    int   items_accepted = 0;
    int   results_seen = 0;
    int   src_gap = 0;
    int   sink_stall = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    int   idle_cycles = 0;
    bit   src_calm = 1'b0;
    bit   sink_calm = 1'b0;
    logic hold_active = 1'b0;

    cigar_match_run_expander #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (errors < PRINT_LIMIT)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // The open run as an emitted operation.
    function automatic t_cigar_op run_as_op();
        t_cigar_op op;
        op.code = run_mis ? cmre_pkg::OP_SEQ_MISMATCH : cmre_pkg::OP_SEQ_MATCH;
        op.len  = cmre_pkg::LEN_W'(run_len);
        op.last = 1'b0;
        return op;
    endfunction

    // Works out the = / X operations that one accepted item produces and queues them.
    task automatic expand_cigar_item(input t_cigar_item it);
        t_cigar_op ops[2];
        int        n;
        logic      mis;
        n = 0;
        if (it.kind == KIND_WHOLE_OP) begin
            // A whole operation first flushes any run that was never closed.
            if (run_on) begin
                ops[n] = run_as_op();
                n++;
                run_on  = 1'b0;
                run_len = '0;
            end
            if (it.len != '0) begin
                ops[n] = '{code: it.code, len: it.len, last: 1'b0};
                n++;
            end
        end else begin
            mis = (it.qbase != it.rbase);
            if (run_on && mis != run_mis) begin
                ops[n] = run_as_op();
                n++;
                run_mis = mis;
                run_len = LENGTH_BITS'(1);
            end else if (run_on) begin
                if (run_len != RUN_MAX) run_len++;
            end else begin
                run_on  = 1'b1;
                run_mis = mis;
                run_len = LENGTH_BITS'(1);
            end
            if (it.last) begin
                ops[n] = run_as_op();
                n++;
                run_on  = 1'b0;
                run_len = '0;
            end
        end
        if (n > 0) ops[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_ops.push_back(ops[i]);
    endtask

    // Whole operation with random values in the fields that it does not use.
    task automatic push_whole(input logic [cmre_pkg::CODE_W-1:0] code,
                              input logic [cmre_pkg::LEN_W-1:0] len);
        t_cigar_item it;
        it.kind  = KIND_WHOLE_OP;
        it.code  = code;
        it.len   = len;
        it.qbase = cmre_pkg::BASE_W'($urandom);
        it.rbase = cmre_pkg::BASE_W'($urandom);
        it.last  = 1'($urandom);
        pending_items.push_back(it);
    endtask

    // Aligned column with random values in the fields that it does not use.
    task automatic push_column(input logic [cmre_pkg::BASE_W-1:0] qbase,
                               input logic [cmre_pkg::BASE_W-1:0] rbase,
                               input logic last);
        t_cigar_item it;
        it.kind  = KIND_COLUMN;
        it.code  = cmre_pkg::CODE_W'($urandom);
        it.len   = cmre_pkg::LEN_W'($urandom);
        it.qbase = qbase;
        it.rbase = rbase;
        it.last  = last;
        pending_items.push_back(it);
    endtask

    // Column whose bases agree with the given probability in percent.
    task automatic push_random_column(input int match_pct, input logic last);
        logic [cmre_pkg::BASE_W-1:0] q;
        q = cmre_pkg::BASE_W'($urandom);
        if ($urandom_range(0, 99) < match_pct)
            push_column(q, q, last);
        else
            push_column(q, q ^ cmre_pkg::BASE_W'($urandom_range(1, 255)), last);
    endtask

    // Stimulus: directed cases, then random CIGAR strings.
    initial begin
        int          pick;
        int          n_cols;
        int          match_pct;
        int          r;
        logic [cmre_pkg::CODE_W-1:0] code;
        logic [cmre_pkg::LEN_W-1:0]  len;
        t_cigar_item noise;
        t_cigar_op   left;

        // Length extremes, a dropped operation and op codes 0 to 8 and 15 passed through.
        push_whole(OP_INS, 28'd1);
        push_whole(OP_ALN_MATCH, LEN_ALL_ONES);
        push_whole(OP_DEL, '0);
        for (int c = OP_ALN_MATCH; c <= cmre_pkg::OP_SEQ_MISMATCH; c++)
            push_whole(cmre_pkg::CODE_W'(c), cmre_pkg::LEN_W'($urandom_range(1, 1000)));
        push_whole(OP_CODE_TOP, LEN_ALL_ONES);

        // Single-column M operations, one matching and one not, at the base extremes.
        push_column(8'h00, 8'h00, 1'b1);
        push_column(8'hFF, 8'h00, 1'b1);

        // Match, mismatch and match runs within one M operation.
        push_column(8'h05, 8'h05, 1'b0);
        push_column(8'hFF, 8'hFF, 1'b0);
        push_column(8'h00, 8'hFF, 1'b0);
        push_column(8'h01, 8'h02, 1'b0);
        push_column(8'h09, 8'h09, 1'b1);

        // M operation left open, then closed by a whole operation of nonzero length.
        push_column(8'h03, 8'h03, 1'b0);
        push_column(8'h04, 8'h04, 1'b0);
        push_whole(OP_SOFT_CLIP, 28'd7);

        // M operation left open, then closed by an operation that is itself dropped.
        push_column(8'h07, 8'h08, 1'b0);
        push_whole(OP_HARD_CLIP, '0);

        // Random CIGAR strings: mostly well-formed, some unterminated M and some noise.
        while (pending_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                n_cols = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(1, 12);
                match_pct = $urandom_range(0, 100);
                for (int k = 0; k < n_cols; k++)
                    push_random_column(match_pct, k == n_cols - 1);
            end else if (pick < 88) begin
                case ($urandom_range(0, 7))
                    0:       code = OP_INS;
                    1:       code = OP_DEL;
                    2:       code = OP_SKIP;
                    3:       code = OP_SOFT_CLIP;
                    4:       code = OP_HARD_CLIP;
                    5:       code = OP_PAD;
                    6:       code = cmre_pkg::OP_SEQ_MATCH;
                    default: code = cmre_pkg::OP_SEQ_MISMATCH;
                endcase
                r = $urandom_range(0, 99);
                if (r < 6)       len = '0;
                else if (r < 12) len = cmre_pkg::LEN_W'($urandom);
                else             len = cmre_pkg::LEN_W'($urandom_range(1, 300));
                push_whole(code, len);
            end else if (pick < 95) begin
                n_cols = $urandom_range(1, 8);
                match_pct = $urandom_range(0, 100);
                for (int k = 0; k < n_cols; k++)
                    push_random_column(match_pct, 1'b0);
            end else begin
                noise = t_cigar_item'(ITEM_W'({$urandom, $urandom}));
                pending_items.push_back(noise);
            end
        end
        total_items = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < total_items || expected_ops.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        while (expected_ops.size() != 0) begin
            left = expected_ops.pop_front();
            report_mismatch("missing result op code", left.code, -1);
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Slave-side driver: presents pending items with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expand_cigar_item(cur_item);
                items_accepted++;
                if (items_accepted % 250 == 0) src_calm = ($urandom_range(0, 3) == 0);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_item.rbase, cur_item.qbase, cur_item.len, cur_item.code};
                    s_axis_tuser  <= cur_item.kind;
                    s_axis_tlast  <= cur_item.last;
                    // Keep offering items back to back while the receiver holds off.
                    src_gap = (src_calm || hold_active) ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Compares one master-side transaction with the oldest expected operation.
    task automatic check_result(input logic [cmre_pkg::CODE_W-1:0] code,
                                input logic [cmre_pkg::LEN_W-1:0] len,
                                input logic last);
        t_cigar_op want;
        if (expected_ops.size() == 0) begin
            report_mismatch("unexpected result op code", -1, code);
            return;
        end
        want = expected_ops.pop_front();
        if (code != want.code) report_mismatch("op code", want.code, code);
        if (len != want.len)   report_mismatch("op length", want.len, len);
        if (last != want.last) report_mismatch("tlast", want.last, last);
    endtask

    // Master-side monitor: checks results, stalls at random and holds off at length
    // twice, once 300 and again once 1000 results have gone by.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_active   <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata[3:0], m_axis_tdata[31:4], m_axis_tlast);
                results_seen++;
                if (results_seen % 200 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
                hold_active   <= (hold_left != 0);
            end else if (holds_done < 2 && results_seen >= 300 + 700 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_axis_tready <= 1'b0;
                hold_active   <= 1'b1;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 5) == 0) sink_stall = pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/cmre_pkg.sv
rtl/cmre_front.sv
rtl/cmre_queue.sv
rtl/cmre_back.sv
rtl/cigar_match_run_expander.sv
test/cigar_match_run_expander_test.sv
